### rtl/usrac_pkg.sv
package usrac_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 20;
  localparam int unsigned TickWidth     = 20;
  localparam int unsigned DistWidth     = 14;
  localparam int unsigned SpeedWidth    = 16;

  localparam logic [CfgIndexWidth-1:0] CfgThreshold   = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CfgDriveSpeed  = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CfgRevLeft     = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CfgTrigTicks   = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CfgSampleTicks = 3'd4;
  localparam logic [CfgIndexWidth-1:0] CfgBackTicks   = 3'd5;

  localparam logic [2:0] PhIdle  = 3'd0;
  localparam logic [2:0] PhTrig  = 3'd1;
  localparam logic [2:0] PhWait  = 3'd2;
  localparam logic [2:0] PhCount = 3'd3;
  localparam logic [2:0] PhBack  = 3'd4;

  localparam logic [1:0] MmStop = 2'd0;
  localparam logic [1:0] MmFwd  = 2'd1;
  localparam logic [1:0] MmRev  = 2'd2;

  localparam logic [DistWidth-1:0] DistMax = 14'd16383;

  // reciprocal of 5 scaled by 2^34, exact for 32-bit dividends
  localparam logic [31:0] RecipFive = 32'hCCCC_CCCD;

endpackage

### rtl/ultrasonic_range_avoid_controller.sv
// channel   direction  handshake                  payload
// in        sink       in_valid_i / in_ready_o    echo_level_i, start_request_i
// out       source     out_valid_o / out_ready_i  trigger_level_o .. busy_res_o
// cfg       sink       cfg_we_i                   cfg_index_i, cfg_data_i
//
// one request per clock unless out_ready_i holds the result: phase update and the
// distance scaling (count*3/20 via a constant reciprocal multiply) are done between the input and the result register
// every register resets to its documented value at once, no clearing pass
// the result register holds while out_ready_i is low; a new request is taken
// whenever that register is empty or being emptied in the same cycle
module ultrasonic_range_avoid_controller #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [usrac_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [usrac_pkg::CfgDataWidth-1:0]    cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  echo_level_i,
  input  logic                                  start_request_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  trigger_level_o,
  output logic                                  reverse_drive_o,
  output logic [usrac_pkg::SpeedWidth-1:0]      left_speed_o,
  output logic [usrac_pkg::SpeedWidth-1:0]      right_speed_o,
  output logic                                  distance_valid_o,
  output logic [usrac_pkg::DistWidth-1:0]       distance_cm_o,
  output logic                                  busy_res_o
);
  import usrac_pkg::*;

  logic [DistWidth-1:0]   threshold_q;
  logic [SpeedWidth-1:0]  drive_speed_q;
  logic [SpeedWidth-1:0]  rev_left_q;
  logic [7:0]             trig_ticks_q;
  logic [7:0]             sample_ticks_q;
  logic [TickWidth-1:0]   back_ticks_q;

  logic [2:0]             phase_q, phase_d;
  logic [TickWidth-1:0]   tick_q, tick_d;
  logic [COUNT_WIDTH-1:0] echo_count_q, echo_count_d;
  logic [DistWidth-1:0]   last_dist_q, last_dist_d;
  logic [1:0]             motor_q, motor_d;

  logic                   out_valid_q;
  logic                   trig_q, rev_q, dvalid_q, busy_q;
  logic [SpeedWidth-1:0]  left_q, right_q;
  logic [DistWidth-1:0]   dist_q;

  logic                   trig_d, dvalid_d;
  logic                   accept;
  logic [TickWidth-1:0]   trig_len, back_len;
  logic [TickWidth-1:0]   sample_m1;
  logic [COUNT_WIDTH+1:0] count_x3;
  logic [63:0]            div_prod;
  logic [29:0]            div_quot;
  logic [DistWidth-1:0]   dist_new;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q    <= 14'd20;
      drive_speed_q  <= '0;
      rev_left_q     <= 16'd600;
      trig_ticks_q   <= 8'd15;
      sample_ticks_q <= 8'd8;
      back_ticks_q   <= 20'd500000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgThreshold:   threshold_q    <= cfg_data_i[DistWidth-1:0];
        CfgDriveSpeed:  drive_speed_q  <= cfg_data_i[SpeedWidth-1:0];
        CfgRevLeft:     rev_left_q     <= cfg_data_i[SpeedWidth-1:0];
        CfgTrigTicks:   trig_ticks_q   <= cfg_data_i[7:0];
        CfgSampleTicks: sample_ticks_q <= cfg_data_i[7:0];
        CfgBackTicks:   back_ticks_q   <= cfg_data_i[TickWidth-1:0];
        default: ;
      endcase
    end
  end

  assign trig_len  = (trig_ticks_q == '0) ? TickWidth'(1) : TickWidth'(trig_ticks_q);
  assign back_len  = (back_ticks_q == '0) ? TickWidth'(1) : back_ticks_q;
  assign sample_m1 = (sample_ticks_q == '0) ? '0 : TickWidth'(sample_ticks_q - 8'd1);

  // count*3/20 = floor(floor(3*count/4)/5)
  assign count_x3 = {2'b00, echo_count_q} + {1'b0, echo_count_q, 1'b0};
  assign div_prod = {{(32-COUNT_WIDTH){1'b0}}, count_x3[COUNT_WIDTH+1:2]} * RecipFive;
  assign div_quot = div_prod[63:34];
  assign dist_new = (|div_quot[29:DistWidth]) ? DistMax : div_quot[DistWidth-1:0];

  always_comb begin
    phase_d      = phase_q;
    tick_d       = tick_q;
    echo_count_d = echo_count_q;
    last_dist_d  = last_dist_q;
    motor_d      = motor_q;
    trig_d       = 1'b0;
    dvalid_d     = 1'b0;
    case (phase_q)
      PhIdle: begin
        if (start_request_i) begin
          phase_d = PhTrig;
          tick_d  = TickWidth'(1);
          trig_d  = 1'b1;
        end
      end
      PhTrig: begin
        if (tick_q >= trig_len) begin
          phase_d = PhWait;
          tick_d  = '0;
        end else begin
          tick_d = tick_q + TickWidth'(1);
          trig_d = 1'b1;
        end
      end
      PhWait: begin
        if (echo_level_i) begin
          phase_d      = PhCount;
          echo_count_d = COUNT_WIDTH'(1);
          tick_d       = sample_m1;
        end
      end
      PhCount: begin
        if (tick_q != '0) begin
          tick_d = tick_q - TickWidth'(1);
        end else if (echo_level_i) begin
          if (echo_count_q != '1) begin
            echo_count_d = echo_count_q + COUNT_WIDTH'(1);
          end
          tick_d = sample_m1;
        end else begin
          last_dist_d = dist_new;
          dvalid_d    = 1'b1;
          if (dist_new < threshold_q) begin
            phase_d = PhBack;
            motor_d = MmRev;
            tick_d  = TickWidth'(1);
          end else begin
            phase_d = PhIdle;
            motor_d = MmFwd;
            tick_d  = '0;
          end
        end
      end
      PhBack: begin
        if (tick_q >= back_len) begin
          phase_d = PhIdle;
          motor_d = MmFwd;
          tick_d  = '0;
        end else begin
          tick_d = tick_q + TickWidth'(1);
        end
      end
      default: begin
        phase_d = PhIdle;
        tick_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      tick_q       <= '0;
      echo_count_q <= '0;
      last_dist_q  <= '0;
      motor_q      <= MmStop;
    end else if (accept) begin
      phase_q      <= phase_d;
      tick_q       <= tick_d;
      echo_count_q <= echo_count_d;
      last_dist_q  <= last_dist_d;
      motor_q      <= motor_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q   <= 1'b0;
      rev_q    <= 1'b0;
      left_q   <= '0;
      right_q  <= '0;
      dvalid_q <= 1'b0;
      dist_q   <= '0;
      busy_q   <= 1'b0;
    end else if (accept) begin
      trig_q   <= trig_d;
      rev_q    <= (motor_d == MmRev);
      left_q   <= (motor_d == MmRev) ? rev_left_q :
                  (motor_d == MmFwd) ? drive_speed_q : '0;
      right_q  <= (motor_d == MmStop) ? '0 : drive_speed_q;
      dvalid_q <= dvalid_d;
      dist_q   <= last_dist_d;
      busy_q   <= (phase_d != PhIdle);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign trigger_level_o  = trig_q;
  assign reverse_drive_o  = rev_q;
  assign left_speed_o     = left_q;
  assign right_speed_o    = right_q;
  assign distance_valid_o = dvalid_q;
  assign distance_cm_o    = dist_q;
  assign busy_res_o       = busy_q;

endmodule
